>>> design/sspp_pkg.sv
// types and constants shared by the status packet parser modules
`default_nettype none

package sspp_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] LEN_MIN   = 8'd2;
   localparam logic [7:0] LEN_MAX   = 8'd29;
   localparam int unsigned SLOT_COUNT = 5;

   // header slots and the two parameter slots that are reported
   localparam logic [2:0] SLOT_ID     = 3'd0;
   localparam logic [2:0] SLOT_LENGTH = 3'd1;
   localparam logic [2:0] SLOT_ERROR  = 3'd2;
   localparam logic [2:0] SLOT_PARAM0 = 3'd3;
   localparam logic [2:0] SLOT_PARAM1 = 3'd4;

   typedef enum logic [3:0] {
      PHASE_HUNT   = 4'b0001,
      PHASE_HEADER = 4'b0010,
      PHASE_PARAMS = 4'b0100,
      PHASE_CHECK  = 4'b1000
   } sspp_phase_type;

   typedef struct packed {
      logic [7:0] servo_id;
      logic [4:0] packet_length;
      logic [7:0] error_flags;
      logic [7:0] param_first;
      logic [7:0] param_second;
      logic [7:0] checksum_byte;
   } sspp_result_type;

endpackage

`default_nettype wire

>>> design/sspp_parse.sv
// byte-level frame parser: sync hunt, header, parameters and checksum
`default_nettype none

module sspp_parse (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      byte_take,
   input  wire logic                      listen,
   input  wire logic [7:0]                rx_byte,
   output      logic                      res_valid,
   output      sspp_pkg::sspp_result_type res_word
);
   import sspp_pkg::*;

   sspp_phase_type phase_ff, phase_in;
   logic [4:0]     count_ff, count_in;
   logic [7:0]     slot_ff [SLOT_COUNT];
   logic [7:0]     slot_in [SLOT_COUNT];
   logic [4:0]     count_inc;
   logic [7:0]     len;
   logic [7:0]     len_less2;
   logic           bad_len;

   assign count_inc = count_ff + 5'd1;
   assign len       = slot_ff[SLOT_LENGTH];
   assign len_less2 = len - LEN_MIN;
   assign bad_len   = (len < LEN_MIN) || (len > LEN_MAX);

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      slot_in   = slot_ff;
      res_valid = 1'b0;
      res_word  = '0;
      if (byte_take && listen) begin
         case (phase_ff)
            PHASE_HUNT: begin
               if (rx_byte == SYNC_BYTE) begin
                  if (count_inc >= 5'd2) begin
                     phase_in = PHASE_HEADER;
                     count_in = '0;
                  end else begin
                     count_in = count_inc;
                  end
               end else begin
                  count_in = '0;
               end
            end
            PHASE_HEADER: begin
               if (count_ff == {2'b00, SLOT_ID})     slot_in[SLOT_ID]     = rx_byte;
               if (count_ff == {2'b00, SLOT_LENGTH}) slot_in[SLOT_LENGTH] = rx_byte;
               if (count_ff == {2'b00, SLOT_ERROR})  slot_in[SLOT_ERROR]  = rx_byte;
               count_in = count_inc;
               if (count_inc >= 5'd3) begin
                  count_in = '0;
                  if (bad_len) begin
                     phase_in = PHASE_HUNT;
                  end else if (len == LEN_MIN) begin
                     phase_in = PHASE_CHECK;
                  end else begin
                     phase_in = PHASE_PARAMS;
                  end
               end
            end
            PHASE_PARAMS: begin
               // only the first two parameters are ever reported
               if (count_ff == 5'd0) slot_in[SLOT_PARAM0] = rx_byte;
               if (count_ff == 5'd1) slot_in[SLOT_PARAM1] = rx_byte;
               count_in = count_inc;
               if (bad_len || ({3'b000, count_inc} >= len_less2)) begin
                  phase_in = PHASE_CHECK;
               end
            end
            PHASE_CHECK: begin
               phase_in = PHASE_HUNT;
               count_in = '0;
               if (!bad_len) begin
                  // checksum lands in slot length+1, over a parameter on short frames
                  if (len == 8'd2) slot_in[SLOT_PARAM0] = rx_byte;
                  if (len == 8'd3) slot_in[SLOT_PARAM1] = rx_byte;
                  res_valid              = 1'b1;
                  res_word.servo_id      = slot_ff[SLOT_ID];
                  res_word.packet_length = len[4:0];
                  res_word.error_flags   = slot_ff[SLOT_ERROR];
                  res_word.param_first   = slot_in[SLOT_PARAM0];
                  res_word.param_second  = slot_in[SLOT_PARAM1];
                  res_word.checksum_byte = rx_byte;
               end
            end
            default: begin
               phase_in = PHASE_HUNT;
               count_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
         count_ff <= '0;
         slot_ff  <= '{default: '0};
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

`default_nettype wire

>>> design/servo_status_packet_parser.sv
// top level of the servo bus status packet parser with a two-word result buffer
//
//   channel | ports                         | direction | word
//   --------+-------------------------------+-----------+------------------------------
//   req     | req_valid/req_ready           | in        | listen flag, received byte
//   rsp     | rsp_valid/rsp_ready           | out       | id, length, error, params, sum
//
// one byte is taken every cycle while the skid is empty; the parser state moves on the
// accepting edge, and a completed packet is registered in the output or skid register
// synchronous reset puts the parser in sync hunt and clears the header slots
// results sit in an output register backed by a skid register, so req_ready
// only drops once both hold a word that rsp has not yet taken
`default_nettype none

module servo_status_packet_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic       req_listen,
   input  wire logic [7:0] req_rx_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_servo_id,
   output      logic [4:0] rsp_packet_length,
   output      logic [7:0] rsp_error_flags,
   output      logic [7:0] rsp_param_first,
   output      logic [7:0] rsp_param_second,
   output      logic [7:0] rsp_checksum_byte
);
   import sspp_pkg::*;

   logic            req_take;
   logic            res_valid;
   sspp_result_type res_word;

   // output register and skid register
   logic            out_valid_ff, out_valid_in;
   sspp_result_type out_word_ff, out_word_in;
   logic            skid_valid_ff, skid_valid_in;
   sspp_result_type skid_word_ff, skid_word_in;
   logic            out_free;

   assign req_ready = !skid_valid_ff;
   assign req_take  = req_valid && req_ready;

   sspp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .byte_take (req_take),
      .listen    (req_listen),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   // output slot opens when empty or when its word leaves this cycle
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // drain the skid first; no byte is taken while it is full
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else if (res_valid) begin
            out_valid_in = 1'b1;
            out_word_in  = res_word;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         // output stalled: park the new word in the skid
         skid_valid_in = 1'b1;
         skid_word_in  = res_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_servo_id      = out_word_ff.servo_id;
   assign rsp_packet_length = out_word_ff.packet_length;
   assign rsp_error_flags   = out_word_ff.error_flags;
   assign rsp_param_first   = out_word_ff.param_first;
   assign rsp_param_second  = out_word_ff.param_second;
   assign rsp_checksum_byte = out_word_ff.checksum_byte;

`ifndef SYNTHESIS
   // the skid only ever holds a word behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   // the skid fills only when the output word was stalled
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready))
      else $error("skid filled without an output stall");

   // a parser result comes only from an accepted byte with listen set
   a_result_from_byte: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (req_take && req_listen))
      else $error("parser result without an accepted listening byte");

   // reported frame lengths are always in the legal range
   a_length_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_word_ff.packet_length >= 5'd2) &&
                        (out_word_ff.packet_length <= 5'd29)))
      else $error("reported packet length out of range");
`endif

endmodule

`default_nettype wire
